// ===== design/tun_pkg.sv =====
// shared types, widths and constants for the triangle unit normal block
package tun_pkg;

  localparam int COORD_BITS   = 16;
  localparam int OUT_BITS     = 16;
  localparam int OUT_FRAC_DEF = 14;

  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = 2 * COORD_BITS + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OUT_BITS-1:0]   comp_t;

  typedef struct packed {
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
  } in_t;

  typedef struct packed {
    comp_t unit_x;
    comp_t unit_y;
    comp_t unit_z;
    logic  degenerate;
  } out_t;

  typedef struct packed {
    logic                  degenerate;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } nrm_t;

endpackage

// ===== design/tun_cross.sv =====
// edge, cross product and squared length pipeline
module tun_cross (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  tun_pkg::in_t              in_data,
  output logic                      out_valid,
  output logic [tun_pkg::SUM_W-1:0] out_sum,
  output tun_pkg::nrm_t             out_nrm
);
  import tun_pkg::*;

  logic [5:0]                 vld_r;
  logic signed [EDGE_W-1:0]   e1_r [3];
  logic signed [EDGE_W-1:0]   e2_r [3];
  logic signed [PROD_W-1:0]   p_r [6];
  logic signed [CROSS_W-1:0]  n_r [3];
  logic signed [CROSS_W-1:0]  n_abs [3];
  nrm_t                       nrm4_r;
  nrm_t                       nrm5_r;
  nrm_t                       nrm6_r;
  nrm_t                       nrm6_nxt;
  logic [SQ_W-1:0]            sq_r [3];
  logic [SUM_W-1:0]           sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_abs[i] = n_r[i][CROSS_W-1] ? -n_r[i] : n_r[i];
    end
  end

  always_comb begin
    nrm6_nxt            = nrm5_r;
    nrm6_nxt.degenerate = (nrm5_r.mag == '0);
  end

  always_ff @(posedge clk) begin
    e1_r[0] <= EDGE_W'(in_data.v1_x) - EDGE_W'(in_data.v0_x);
    e1_r[1] <= EDGE_W'(in_data.v1_y) - EDGE_W'(in_data.v0_y);
    e1_r[2] <= EDGE_W'(in_data.v1_z) - EDGE_W'(in_data.v0_z);
    e2_r[0] <= EDGE_W'(in_data.v2_x) - EDGE_W'(in_data.v0_x);
    e2_r[1] <= EDGE_W'(in_data.v2_y) - EDGE_W'(in_data.v0_y);
    e2_r[2] <= EDGE_W'(in_data.v2_z) - EDGE_W'(in_data.v0_z);

    p_r[0] <= e1_r[1] * e2_r[2];
    p_r[1] <= e1_r[2] * e2_r[1];
    p_r[2] <= e1_r[2] * e2_r[0];
    p_r[3] <= e1_r[0] * e2_r[2];
    p_r[4] <= e1_r[0] * e2_r[1];
    p_r[5] <= e1_r[1] * e2_r[0];

    for (int i = 0; i < 3; i++) begin
      n_r[i] <= CROSS_W'(p_r[2*i]) - CROSS_W'(p_r[2*i+1]);
    end

    nrm4_r.degenerate <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      nrm4_r.neg[i] <= n_r[i][CROSS_W-1];
      nrm4_r.mag[i] <= n_abs[i][MAG_W-1:0];
    end

    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= nrm4_r.mag[i] * nrm4_r.mag[i];
    end
    nrm5_r <= nrm4_r;

    sum_r  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    nrm6_r <= nrm6_nxt;
  end

  assign out_valid = vld_r[5];
  assign out_sum   = sum_r;
  assign out_nrm   = nrm6_r;

endmodule

// ===== design/tun_sqrt.sv =====
// pipelined floor square root, two radicand bits per stage
module tun_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [tun_pkg::SUM_W-1:0]  in_sum,
  input  tun_pkg::nrm_t              in_nrm,
  output logic                       out_valid,
  output logic [tun_pkg::ROOT_W-1:0] out_root,
  output tun_pkg::nrm_t              out_nrm
);
  import tun_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic              vld_r  [ROOT_W];
  logic [SUM_W-1:0]  x_r    [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  nrm_t              nrm_r  [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic              v_in;
    logic [SUM_W-1:0]  x_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    nrm_t              n_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic              ge;

    if (g == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = in_sum;
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = in_nrm;
    end else begin : g_next
      assign v_in    = vld_r[g-1];
      assign x_in    = x_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign n_in    = nrm_r[g-1];
    end

    always_comb begin
      rem_sh  = {rem_in[REM_W-3:0], x_in[SUM_W-1 -: 2]};
      trial   = {root_in, 2'b01};
      ge      = (rem_sh >= trial);
      rem_nxt = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      x_r[g]    <= x_in << 2;
      rem_r[g]  <= rem_nxt;
      root_r[g] <= {root_in[ROOT_W-2:0], ge};
      nrm_r[g]  <= n_in;
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_nrm   = nrm_r[ROOT_W-1];

endmodule

// ===== design/tun_div.sv =====
// pipelined restoring divide of three magnitudes by the length, one quotient bit per stage
module tun_div #(
  parameter int FRAC = tun_pkg::OUT_FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [tun_pkg::ROOT_W-1:0] in_root,
  input  tun_pkg::nrm_t              in_nrm,
  output logic                       out_valid,
  output logic [2:0][FRAC:0]         out_q,
  output tun_pkg::nrm_t              out_nrm
);
  import tun_pkg::*;

  localparam int QW = FRAC + 1;
  localparam int DW = ROOT_W + 1;

  logic                  vld_r  [QW];
  logic [ROOT_W-1:0]     root_r [QW];
  nrm_t                  nrm_r  [QW];
  logic [2:0][DW-1:0]    rem_r  [QW];
  logic [2:0][QW-1:0]    q_r    [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic               v_in;
    logic [ROOT_W-1:0]  root_in;
    nrm_t               n_in;
    logic [2:0][DW-1:0] rem_sh;
    logic [2:0][QW-1:0] q_in;
    logic [2:0][DW-1:0] rem_nxt;
    logic [2:0]         ge;

    if (g == 0) begin : g_first
      assign v_in    = in_valid;
      assign root_in = in_root;
      assign n_in    = in_nrm;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_sh[l] = DW'(in_nrm.mag[l]);
        assign q_in[l]   = '0;
      end
    end else begin : g_next
      assign v_in    = vld_r[g-1];
      assign root_in = root_r[g-1];
      assign n_in    = nrm_r[g-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_sh[l] = {rem_r[g-1][l][DW-2:0], 1'b0};
        assign q_in[l]   = q_r[g-1][l];
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        ge[l]      = (rem_sh[l] >= DW'(root_in));
        rem_nxt[l] = ge[l] ? rem_sh[l] - DW'(root_in) : rem_sh[l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      root_r[g] <= root_in;
      nrm_r[g]  <= n_in;
      rem_r[g]  <= rem_nxt;
      for (int l = 0; l < 3; l++) begin
        q_r[g][l] <= {q_in[l][QW-2:0], ge[l]};
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_q     = q_r[QW-1];
  assign out_nrm   = nrm_r[QW-1];

endmodule

// ===== design/triangle_unit_normal_top.sv =====
// top level of the triangle unit normal block
// Usage: drive a triangle (three Q8.8 vertices) on in_data and raise start for
// one cycle; a transfer happens on every rising edge with start high and busy
// low. busy is always low, so a new triangle may enter on every clock.
// Each triangle gives one result: out_valid is high for exactly one cycle with
// the Q1.14 unit normal and the degenerate flag on out_data. The receiver
// cannot hold results off and must take each one when it is shown.
// Throughput is one triangle per cycle. The depth is set by the cross product
// and squaring stages, one square root stage per root bit, one divide stage
// per quotient bit and the output register.
// Results leave in transfer order. A synchronous active-low reset clears
// every stage valid bit, dropping triangles in flight; no clearing pass.
module triangle_unit_normal_top #(
  parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  tun_pkg::in_t  in_data,
  output logic          out_valid,
  output tun_pkg::out_t out_data
);
  import tun_pkg::*;

  localparam int QW = OUT_FRAC_BITS + 1;
  localparam int CW = ((QW > OUT_BITS) ? QW : OUT_BITS) + 1;
  localparam logic [CW-1:0] LIM_POS = CW'(2 ** (OUT_BITS - 1) - 1);
  localparam logic [CW-1:0] LIM_NEG = CW'(2 ** (OUT_BITS - 1));

  logic                   cr_valid;
  logic [SUM_W-1:0]       cr_sum;
  nrm_t                   cr_nrm;
  logic                   sq_valid;
  logic [ROOT_W-1:0]      sq_root;
  nrm_t                   sq_nrm;
  logic                   dv_valid;
  logic [2:0][QW-1:0]     dv_q;
  nrm_t                   dv_nrm;
  logic [CW-1:0]          q_ext [3];
  logic [CW-1:0]          q_lim [3];
  comp_t                  comp  [3];
  logic                   out_valid_r;
  out_t                   out_data_r;
  out_t                   out_data_nxt;

  assign busy = 1'b0;

  tun_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_data   (in_data),
    .out_valid (cr_valid),
    .out_sum   (cr_sum),
    .out_nrm   (cr_nrm)
  );

  tun_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cr_valid),
    .in_sum    (cr_sum),
    .in_nrm    (cr_nrm),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_nrm   (sq_nrm)
  );

  tun_div #(
    .FRAC (OUT_FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_nrm    (sq_nrm),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_nrm   (dv_nrm)
  );

  // sign and saturate each component, zeroing all three for a degenerate triangle
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      q_ext[l] = CW'(dv_q[l]);
      if (dv_nrm.neg[l]) begin
        q_lim[l] = (q_ext[l] > LIM_NEG) ? LIM_NEG : q_ext[l];
        comp[l]  = OUT_BITS'(-q_lim[l]);
      end else begin
        q_lim[l] = (q_ext[l] > LIM_POS) ? LIM_POS : q_ext[l];
        comp[l]  = OUT_BITS'(q_lim[l]);
      end
      if (dv_nrm.degenerate) begin
        comp[l] = '0;
      end
    end
    out_data_nxt.unit_x     = comp[0];
    out_data_nxt.unit_y     = comp[1];
    out_data_nxt.unit_z     = comp[2];
    out_data_nxt.degenerate = dv_nrm.degenerate;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
